@@ sv/gru_pkg.sv @@
package gru_pkg;

   localparam int DATA_WIDTH     = 16;
   localparam int COEF_FRAC_BITS = 14;

   localparam int COEF_W   = COEF_FRAC_BITS + 2;
   localparam int COEF_ONE = 1 << COEF_FRAC_BITS;
   localparam int OUT_W    = DATA_WIDTH + 1;
   localparam int MUL_W    = (DATA_WIDTH + 1 > COEF_W) ? DATA_WIDTH + 1 : COEF_W;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int N_W      = 2 * DATA_WIDTH;
   localparam int K_W      = COEF_FRAC_BITS + 1;
   localparam int ACC_W    = 2 * DATA_WIDTH + 2 * COEF_FRAC_BITS + 4;
   localparam int SH_W     = $clog2(ACC_W);
   localparam int BIT_MAX  = (DATA_WIDTH - 1 > COEF_FRAC_BITS) ? DATA_WIDTH - 1 : COEF_FRAC_BITS;
   localparam int BIT_W    = $clog2(BIT_MAX + 1);

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef enum logic [1:0] {
      REQ_GENERATE    = 2'd0,
      REQ_APPLY_LEFT  = 2'd1,
      REQ_APPLY_RIGHT = 2'd2,
      REQ_INVERT      = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SUM,
      ST_ROOT,
      ST_ROUND,
      ST_COS,
      ST_SIN_INIT,
      ST_SIN,
      ST_SIN_END,
      ST_AP0,
      ST_AP1,
      ST_AP2,
      ST_AP3,
      ST_AP4,
      ST_DONE
   } state_type;

   typedef struct packed {
      acc_type           rem;
      acc_type           bacc;
      acc_type           base;
      logic [SH_W-1:0]   sh_b;
      logic [SH_W-1:0]   sh_t;
   } rec_req_type;

   typedef struct packed {
      acc_type diff;
      logic    fits;
   } rec_rsp_type;

endpackage

@@ sv/gru_req_if.sv @@
interface gru_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             req_type;
   logic signed [gru_pkg::DATA_WIDTH-1:0]  first_value;
   logic signed [gru_pkg::DATA_WIDTH-1:0]  second_value;

   modport source (output valid, output req_type, output first_value, output second_value,
                   input ready);
   modport sink (input valid, input req_type, input first_value, input second_value,
                 output ready);
endinterface

@@ sv/gru_rsp_if.sv @@
interface gru_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [gru_pkg::OUT_W-1:0]  out_first;
   logic signed [gru_pkg::OUT_W-1:0]  out_second;
   logic signed [gru_pkg::OUT_W-1:0]  out_radius;

   modport source (output valid, output out_first, output out_second, output out_radius,
                   input ready);
   modport sink (input valid, input out_first, input out_second, input out_radius,
                 output ready);
endinterface

@@ sv/gru_mul.sv @@
module gru_mul (
   input  logic                                clock,
   input  logic signed [gru_pkg::MUL_W-1:0]    op_a,
   input  logic signed [gru_pkg::MUL_W-1:0]    op_b,
   output logic signed [gru_pkg::PROD_W-1:0]   product
);

   logic signed [gru_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule

@@ sv/gru_rec.sv @@
module gru_rec (
   input  gru_pkg::rec_req_type  rec_req,
   output gru_pkg::rec_rsp_type  rec_rsp
);

   gru_pkg::acc_type diff;

   // One step of the digit recurrence shared by the root and both coefficients.
   assign diff = rec_req.rem - (rec_req.bacc <<< rec_req.sh_b) - (rec_req.base <<< rec_req.sh_t);

   assign rec_rsp.diff = diff;
   assign rec_rsp.fits = ~diff[gru_pkg::ACC_W-1];

endmodule

@@ sv/givens_rotation_unit.sv @@
// Channel   Dir   Payload                                   Handshake
// req_in    in    req_type, first_value, second_value       valid/ready
// rsp_out   out   out_first, out_second, out_radius         valid/ready
// A generate with both inputs non-zero runs two squares on the multiplier, 16 root
// steps and 15 steps for each coefficient on the recurrence unit. Apply runs four
// products through the multiplier; invert and the trivial generate cases use neither.
// Synchronous reset restores the identity rotation.
// A new item is taken while a finished result still waits in the output register.
module givens_rotation_unit (
   input logic         clock,
   input logic         reset,
   gru_req_if.sink     req_in,
   gru_rsp_if.source   rsp_out
);

   localparam int DW = gru_pkg::DATA_WIDTH;
   localparam int FB = gru_pkg::COEF_FRAC_BITS;
   localparam int OW = gru_pkg::OUT_W;
   localparam int CW = gru_pkg::COEF_W;
   localparam int MW = gru_pkg::MUL_W;
   localparam int PW = gru_pkg::PROD_W;
   localparam int SW = gru_pkg::SUM_W;
   localparam int NW = gru_pkg::N_W;
   localparam int KW = gru_pkg::K_W;
   localparam int AW = gru_pkg::ACC_W;
   localparam int HW = gru_pkg::SH_W;
   localparam int BW = gru_pkg::BIT_W;

   gru_pkg::state_type      state_ff, state_in;
   gru_pkg::req_kind_type   type_ff, type_in, req_kind;

   logic signed [DW-1:0]    x_ff, x_in, y_ff, y_in;
   logic [NW-1:0]           ma2_ff, ma2_in, mb2_ff, mb2_in, n_ff, n_in;
   gru_pkg::acc_type        rem_ff, rem_in, bacc_ff, bacc_in;
   logic [BW-1:0]           bit_ff, bit_in;
   logic [KW-1:0]           k_ff, k_in;
   logic signed [PW-1:0]    acc_ff, acc_in;
   logic signed [OW-1:0]    res_first_ff, res_first_in;
   logic signed [OW-1:0]    res_second_ff, res_second_in;
   logic signed [OW-1:0]    res_radius_ff, res_radius_in;
   logic signed [CW-1:0]    rot_cos_ff, rot_cos_in, rot_sin_ff, rot_sin_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]    rsp_first_ff, rsp_first_in;
   logic signed [OW-1:0]    rsp_second_ff, rsp_second_in;
   logic signed [OW-1:0]    rsp_radius_ff, rsp_radius_in;

   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_prod;
   gru_pkg::rec_req_type    rec_req;
   gru_pkg::rec_rsp_type    rec_rsp;

   logic [DW-1:0]           mag_a, mag_b;
   logic signed [MW-1:0]    sq_a, sq_b;
   gru_pkg::acc_type        n_ext, ma2_ext, mb2_ext;
   logic signed [OW-1:0]    root_d;
   logic signed [SW-1:0]    sum_ap;
   logic signed [CW-1:0]    coef_s;

   function automatic logic signed [OW-1:0] round_q(input logic signed [SW-1:0] v);
      logic [SW-1:0] mag;
      logic [SW-1:0] rnd;
      logic [SW-1:0] res;
      mag = v[SW-1] ? SW'(-v) : SW'(v);
      rnd = (mag + (SW'(1) << (FB - 1))) >> FB;
      res = v[SW-1] ? SW'(-rnd) : rnd;
      return res[OW-1:0];
   endfunction

   gru_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_prod)
   );

   gru_rec u_rec (
      .rec_req (rec_req),
      .rec_rsp (rec_rsp)
   );

   assign req_kind = gru_pkg::req_kind_type'(req_in.req_type);
   assign req_in.ready = (state_ff == gru_pkg::ST_IDLE);

   assign mag_a   = x_ff[DW-1] ? DW'(-x_ff) : DW'(x_ff);
   assign mag_b   = y_ff[DW-1] ? DW'(-y_ff) : DW'(y_ff);
   assign sq_a    = $signed({{(MW - DW){1'b0}}, mag_a});
   assign sq_b    = $signed({{(MW - DW){1'b0}}, mag_b});
   assign n_ext   = $signed({{(AW - NW){1'b0}}, n_ff});
   assign ma2_ext = $signed({{(AW - NW){1'b0}}, ma2_ff});
   assign mb2_ext = $signed({{(AW - NW){1'b0}}, mb2_ff});
   assign root_d  = OW'(bacc_ff) + OW'(rem_ff > bacc_ff);
   assign coef_s  = (x_ff[DW-1] ^ y_ff[DW-1]) ? -CW'(k_ff) : CW'(k_ff);

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ma2_in        = ma2_ff;
      mb2_in        = mb2_ff;
      n_in          = n_ff;
      rem_in        = rem_ff;
      bacc_in       = bacc_ff;
      bit_in        = bit_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      res_radius_in = res_radius_ff;
      rot_cos_in    = rot_cos_ff;
      rot_sin_in    = rot_sin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_out.ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_radius_in = rsp_radius_ff;
      mul_a         = '0;
      mul_b         = '0;
      sum_ap        = SW'(acc_ff) + SW'(mul_prod);
      rec_req.rem   = rem_ff;
      rec_req.bacc  = bacc_ff;
      rec_req.base  = n_ext;
      rec_req.sh_b  = HW'(bit_ff) + HW'(2);
      rec_req.sh_t  = (HW'(bit_ff) << 1) + HW'(2);

      case (state_ff)
         gru_pkg::ST_IDLE: begin
            if (req_in.valid) begin
               type_in = req_kind;
               x_in    = req_in.first_value;
               y_in    = req_in.second_value;
               case (req_kind)
                  gru_pkg::REQ_GENERATE: begin
                     if (req_in.second_value == '0) begin
                        rot_cos_in    = CW'(gru_pkg::COEF_ONE);
                        rot_sin_in    = '0;
                        res_first_in  = OW'(gru_pkg::COEF_ONE);
                        res_second_in = '0;
                        res_radius_in = OW'(req_in.first_value);
                        state_in      = gru_pkg::ST_DONE;
                     end else if (req_in.first_value == '0) begin
                        rot_cos_in    = '0;
                        rot_sin_in    = req_in.second_value[DW-1] ?
                                        CW'(-gru_pkg::COEF_ONE) : CW'(gru_pkg::COEF_ONE);
                        res_first_in  = '0;
                        res_second_in = req_in.second_value[DW-1] ?
                                        OW'(-gru_pkg::COEF_ONE) : OW'(gru_pkg::COEF_ONE);
                        res_radius_in = req_in.second_value[DW-1] ?
                                        -OW'(req_in.second_value) : OW'(req_in.second_value);
                        state_in      = gru_pkg::ST_DONE;
                     end else begin
                        state_in = gru_pkg::ST_SQ_A;
                     end
                  end
                  gru_pkg::REQ_APPLY_LEFT, gru_pkg::REQ_APPLY_RIGHT: begin
                     state_in = gru_pkg::ST_AP0;
                  end
                  gru_pkg::REQ_INVERT: begin
                     rot_sin_in    = -rot_sin_ff;
                     res_first_in  = OW'(rot_cos_ff);
                     res_second_in = -OW'(rot_sin_ff);
                     res_radius_in = '0;
                     state_in      = gru_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = gru_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         gru_pkg::ST_SQ_A: begin
            mul_a    = sq_a;
            mul_b    = sq_a;
            state_in = gru_pkg::ST_SQ_B;
         end
         gru_pkg::ST_SQ_B: begin
            ma2_in   = mul_prod[NW-1:0];
            mul_a    = sq_b;
            mul_b    = sq_b;
            state_in = gru_pkg::ST_SUM;
         end
         gru_pkg::ST_SUM: begin
            mb2_in   = mul_prod[NW-1:0];
            n_in     = ma2_ff + mul_prod[NW-1:0];
            rem_in   = $signed({{(AW - NW){1'b0}}, ma2_ff + mul_prod[NW-1:0]});
            bacc_in  = '0;
            bit_in   = BW'(DW - 1);
            state_in = gru_pkg::ST_ROOT;
         end
         gru_pkg::ST_ROOT: begin
            rec_req.base = gru_pkg::acc_type'(1);
            rec_req.sh_b = HW'(bit_ff) + HW'(1);
            rec_req.sh_t = HW'(bit_ff) << 1;
            if (rec_rsp.fits) begin
               rem_in  = rec_rsp.diff;
               bacc_in = bacc_ff + (gru_pkg::acc_type'(1) << bit_ff);
            end
            if (bit_ff == '0) begin
               state_in = gru_pkg::ST_ROUND;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         gru_pkg::ST_ROUND: begin
            res_radius_in = x_ff[DW-1] ? -root_d : root_d;
            rem_in        = (ma2_ext <<< (2 * FB + 2)) - n_ext;
            bacc_in       = -n_ext;
            k_in          = '0;
            bit_in        = BW'(FB);
            state_in      = gru_pkg::ST_COS;
         end
         gru_pkg::ST_COS, gru_pkg::ST_SIN: begin
            if (rec_rsp.fits && !k_ff[KW-1]) begin
               rem_in  = rec_rsp.diff;
               bacc_in = bacc_ff + (n_ext <<< (HW'(bit_ff) + HW'(1)));
               k_in    = k_ff | (KW'(1) << bit_ff);
            end
            if (bit_ff == '0) begin
               state_in = (state_ff == gru_pkg::ST_COS) ? gru_pkg::ST_SIN_INIT
                                                        : gru_pkg::ST_SIN_END;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
         gru_pkg::ST_SIN_INIT: begin
            res_first_in = OW'(k_ff);
            rot_cos_in   = CW'(k_ff);
            rem_in       = (mb2_ext <<< (2 * FB + 2)) - n_ext;
            bacc_in      = -n_ext;
            k_in         = '0;
            bit_in       = BW'(FB);
            state_in     = gru_pkg::ST_SIN;
         end
         gru_pkg::ST_SIN_END: begin
            rot_sin_in    = coef_s;
            res_second_in = OW'(coef_s);
            state_in      = gru_pkg::ST_DONE;
         end
         gru_pkg::ST_AP0: begin
            mul_a    = MW'(rot_cos_ff);
            mul_b    = MW'(x_ff);
            state_in = gru_pkg::ST_AP1;
         end
         gru_pkg::ST_AP1: begin
            acc_in   = mul_prod;
            mul_a    = MW'(rot_sin_ff);
            mul_b    = MW'(y_ff);
            state_in = gru_pkg::ST_AP2;
         end
         gru_pkg::ST_AP2: begin
            sum_ap = (type_ff == gru_pkg::REQ_APPLY_LEFT) ? SW'(acc_ff) + SW'(mul_prod)
                                                          : SW'(acc_ff) - SW'(mul_prod);
            res_first_in = round_q(sum_ap);
            mul_a        = MW'(rot_cos_ff);
            mul_b        = MW'(y_ff);
            state_in     = gru_pkg::ST_AP3;
         end
         gru_pkg::ST_AP3: begin
            acc_in   = mul_prod;
            mul_a    = MW'(rot_sin_ff);
            mul_b    = MW'(x_ff);
            state_in = gru_pkg::ST_AP4;
         end
         gru_pkg::ST_AP4: begin
            sum_ap = (type_ff == gru_pkg::REQ_APPLY_LEFT) ? SW'(acc_ff) - SW'(mul_prod)
                                                          : SW'(acc_ff) + SW'(mul_prod);
            res_second_in = round_q(sum_ap);
            res_radius_in = '0;
            state_in      = gru_pkg::ST_DONE;
         end
         gru_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_out.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = res_first_ff;
               rsp_second_in = res_second_ff;
               rsp_radius_in = res_radius_ff;
               state_in      = gru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gru_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rot_cos_ff   <= CW'(gru_pkg::COEF_ONE);
         rot_sin_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rot_cos_ff   <= rot_cos_in;
         rot_sin_ff   <= rot_sin_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      ma2_ff        <= ma2_in;
      mb2_ff        <= mb2_in;
      n_ff          <= n_in;
      rem_ff        <= rem_in;
      bacc_ff       <= bacc_in;
      bit_ff        <= bit_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      res_radius_ff <= res_radius_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_radius_ff <= rsp_radius_in;
   end

   assign rsp_out.valid      = rsp_valid_ff;
   assign rsp_out.out_first  = rsp_first_ff;
   assign rsp_out.out_second = rsp_second_ff;
   assign rsp_out.out_radius = rsp_radius_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_in.valid && req_in.ready |=> !req_in.ready)
      else $error("block stayed ready after taking an item");

   a_rotation_range: assert property (@(posedge clock) disable iff (reset)
      rot_cos_ff >= 0 && rot_cos_ff <= gru_pkg::COEF_ONE &&
      rot_sin_ff >= -gru_pkg::COEF_ONE && rot_sin_ff <= gru_pkg::COEF_ONE)
      else $error("stored rotation left the unit range");

   a_apply_radius_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == gru_pkg::ST_DONE &&
      (type_ff == gru_pkg::REQ_APPLY_LEFT || type_ff == gru_pkg::REQ_APPLY_RIGHT)
      |-> res_radius_ff == '0)
      else $error("apply result carries a non-zero radius");
`endif

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_WIDTH     = gru_pkg::DATA_WIDTH;
   localparam int COEF_FRAC_BITS = gru_pkg::COEF_FRAC_BITS;
   localparam int COEF_W         = gru_pkg::COEF_W;
   localparam int COEF_ONE       = gru_pkg::COEF_ONE;
   localparam int OUT_W          = gru_pkg::OUT_W;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int RANDOM_ITEMS    = 460;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_first;
      logic signed [OUT_W-1:0] out_second;
      logic signed [OUT_W-1:0] out_radius;
   } rotation_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gru_req_if req_bus ();
   gru_rsp_if rsp_bus ();

   givens_rotation_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus)
   );

   always #5 clock = ~clock;

   rotation_result_type      pending_results[$];
   logic signed [COEF_W-1:0] held_cosine = COEF_W'(COEF_ONE);
   logic signed [COEF_W-1:0] held_sine   = '0;
   int                       error_count = 0;
   int                       cycle_count = 0;
   int                       items_sent  = 0;
   int                       burst_left  = 0;
   int                       hold_off_count  = 0;
   bit                       hold_off_wanted = 1'b0;
   bit                       sender_idles    = 1'b1;
   bit                       receiver_stalls = 1'b1;
   logic [15:0]              stall_pattern   = '1;
   logic [3:0]               pattern_step    = '0;

   function automatic longint root_rounded(longint n);
      longint r;
      longint t;
      r = 0;
      for (int idx = 31; idx >= 0; idx--) begin
         t = r | (longint'(1) << idx);
         if (t * t <= n) r = t;
      end
      if (n - r * r > r) r++;
      return r;
   endfunction

   // Largest k not above one such that (k - 1/2) does not exceed m * 2^F / sqrt(n).
   function automatic longint coef_magnitude(longint m, longint n);
      longint k;
      longint t;
      longint q;
      longint rhs;
      k = 0;
      rhs = (m * m) << (2 * COEF_FRAC_BITS + 2);
      for (int idx = COEF_FRAC_BITS; idx >= 0; idx--) begin
         t = k | (longint'(1) << idx);
         if (t <= COEF_ONE) begin
            q = 2 * t - 1;
            if (q * q * n <= rhs) k = t;
         end
      end
      return k;
   endfunction

   function automatic longint scale_down(longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic rotation_result_type predict_rotation(gru_pkg::req_kind_type kind,
                                                            logic signed [DATA_WIDTH-1:0] a,
                                                            logic signed [DATA_WIDTH-1:0] b);
      rotation_result_type res;
      longint x, y, c, s, r, mag_a, mag_b, sum_sq, sine_mag;
      x = longint'(a);
      y = longint'(b);
      c = longint'(held_cosine);
      s = longint'(held_sine);
      res = '0;
      case (kind)
         gru_pkg::REQ_GENERATE: begin
            if (y == 0) begin
               c = COEF_ONE;
               s = 0;
               r = x;
            end else if (x == 0) begin
               c = 0;
               s = (y < 0) ? -COEF_ONE : COEF_ONE;
               r = (y < 0) ? -y : y;
            end else begin
               mag_a = (x < 0) ? -x : x;
               mag_b = (y < 0) ? -y : y;
               sum_sq = mag_a * mag_a + mag_b * mag_b;
               r = root_rounded(sum_sq);
               if (x < 0) r = -r;
               c = coef_magnitude(mag_a, sum_sq);
               sine_mag = coef_magnitude(mag_b, sum_sq);
               s = ((x < 0) != (y < 0)) ? -sine_mag : sine_mag;
            end
            held_cosine = COEF_W'(c);
            held_sine = COEF_W'(s);
            res.out_first = OUT_W'(c);
            res.out_second = OUT_W'(s);
            res.out_radius = OUT_W'(r);
         end
         gru_pkg::REQ_APPLY_LEFT: begin
            res.out_first = OUT_W'(scale_down(c * x + s * y));
            res.out_second = OUT_W'(scale_down(c * y - s * x));
         end
         gru_pkg::REQ_APPLY_RIGHT: begin
            res.out_first = OUT_W'(scale_down(c * x - s * y));
            res.out_second = OUT_W'(scale_down(s * x + c * y));
         end
         default: begin
            held_sine = -held_sine;
            res.out_first = OUT_W'(held_cosine);
            res.out_second = OUT_W'(held_sine);
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch at cycle %0d: %s got %0d, expected %0d",
               cycle_count, what, got, want);
   endtask

   task automatic send_item(gru_pkg::req_kind_type kind, logic signed [DATA_WIDTH-1:0] a,
                            logic signed [DATA_WIDTH-1:0] b);
      int gap;
      if (sender_idles && burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.first_value <= a;
      req_bus.second_value <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.push_back(predict_rotation(kind, a, b));
      items_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
         2: return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
         3, 4: return DATA_WIDTH'($urandom_range(0, 31) - 16);
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   function automatic gru_pkg::req_kind_type pick_follow_up();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return gru_pkg::REQ_APPLY_LEFT;
         4, 5, 6, 7: return gru_pkg::REQ_APPLY_RIGHT;
         8: return gru_pkg::REQ_INVERT;
         default: return gru_pkg::REQ_GENERATE;
      endcase
   endfunction

   task automatic send_random_item();
      case ($urandom_range(0, 3))
         0: send_item(gru_pkg::REQ_GENERATE, pick_value(), pick_value());
         1: send_item(gru_pkg::REQ_APPLY_LEFT, pick_value(), pick_value());
         2: send_item(gru_pkg::REQ_APPLY_RIGHT, pick_value(), pick_value());
         default: send_item(gru_pkg::REQ_INVERT, pick_value(), pick_value());
      endcase
   endtask

   // Before any generate the identity rotation applies.
   task automatic test_reset_identity();
      send_item(gru_pkg::REQ_APPLY_LEFT, 16'sd32767, -16'sd32768);
      send_item(gru_pkg::REQ_APPLY_RIGHT, -16'sd32768, 16'sd32767);
   endtask

   task automatic test_generate_corners();
      send_item(gru_pkg::REQ_GENERATE, 16'sd0, 16'sd0);
      send_item(gru_pkg::REQ_GENERATE, -16'sd32768, 16'sd0);
      send_item(gru_pkg::REQ_GENERATE, 16'sd32767, 16'sd0);
      send_item(gru_pkg::REQ_GENERATE, 16'sd0, -16'sd32768);
      send_item(gru_pkg::REQ_GENERATE, 16'sd0, 16'sd32767);
      send_item(gru_pkg::REQ_GENERATE, 16'sd3, 16'sd4);
      send_item(gru_pkg::REQ_GENERATE, -16'sd32768, -16'sd32768);
      send_item(gru_pkg::REQ_GENERATE, 16'sd32767, -16'sd32768);
      send_item(gru_pkg::REQ_GENERATE, -16'sd1, 16'sd1);
   endtask

   task automatic test_apply_and_invert();
      send_item(gru_pkg::REQ_GENERATE, -16'sd30000, 16'sd12345);
      send_item(gru_pkg::REQ_APPLY_LEFT, 16'sd32767, 16'sd32767);
      send_item(gru_pkg::REQ_APPLY_LEFT, -16'sd32768, -16'sd32768);
      send_item(gru_pkg::REQ_APPLY_RIGHT, 16'sd32767, -16'sd32768);
      send_item(gru_pkg::REQ_APPLY_RIGHT, -16'sd32768, 16'sd32767);
      send_item(gru_pkg::REQ_INVERT, 16'sd0, 16'sd0);
      send_item(gru_pkg::REQ_APPLY_LEFT, 16'sd1000, -16'sd2000);
      send_item(gru_pkg::REQ_INVERT, -16'sd1, -16'sd1);
      send_item(gru_pkg::REQ_APPLY_RIGHT, 16'sd0, 16'sd0);
      send_item(gru_pkg::REQ_GENERATE, 16'sd1, -16'sd32768);
      send_item(gru_pkg::REQ_APPLY_LEFT, -16'sd32768, 16'sd32767);
   endtask

   task automatic test_streaming();
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      repeat (40) send_random_item();
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_stall();
      sender_idles = 1'b0;
      hold_off_wanted = 1'b1;
      repeat (30) send_random_item();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_sequences();
      int target;
      int follow_ups;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_random_item();
         end else begin
            send_item(gru_pkg::REQ_GENERATE, pick_value(), pick_value());
            follow_ups = $urandom_range(0, 6);
            repeat (follow_ups) begin
               send_item(pick_follow_up(), pick_value(), pick_value());
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_wanted && hold_off_count < HOLD_OFF_CYCLES) begin
         hold_off_count++;
         rsp_bus.ready <= 1'b0;
      end else if (!receiver_stalls) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         if (pattern_step == 0)
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
         rsp_bus.ready <= stall_pattern[pattern_step];
         pattern_step = pattern_step + 1'b1;
      end
   end

   always @(posedge clock) begin
      rotation_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none expected, out_first",
                            longint'(rsp_bus.out_first), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.out_first !== want.out_first)
               report_mismatch("out_first", longint'(rsp_bus.out_first),
                               longint'(want.out_first));
            if (rsp_bus.out_second !== want.out_second)
               report_mismatch("out_second", longint'(rsp_bus.out_second),
                               longint'(want.out_second));
            if (rsp_bus.out_radius !== want.out_radius)
               report_mismatch("out_radius", longint'(rsp_bus.out_radius),
                               longint'(want.out_radius));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.req_type <= gru_pkg::REQ_GENERATE;
      req_bus.first_value <= '0;
      req_bus.second_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_identity();
      test_generate_corners();
      test_apply_and_invert();
      test_streaming();
      test_output_stall();
      test_random_sequences();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

@@ givens_rotation_unit.f @@
sv/gru_pkg.sv
sv/gru_req_if.sv
sv/gru_rsp_if.sv
sv/gru_mul.sv
sv/gru_rec.sv
sv/givens_rotation_unit.sv
tb/sv/testbench.sv
